FILE: sv/pco_pkg.sv
// Shared types, operation codes and helpers for the ARGB pixel color unit.
package pco_pkg;

    localparam int ChanCount = 4;
    localparam int ChanWidth = 8;
    localparam int SumWidth  = 2 * ChanWidth;

    typedef enum logic [1:0] {
        KIND_BLEND   = 2'd0,
        KIND_LERP    = 2'd1,
        KIND_LIGHTEN = 2'd2,
        KIND_DARKEN  = 2'd3
    } kind_t;

    // How the last stage builds the output word.
    typedef enum logic [1:0] {
        SEL_PASS    = 2'd0,
        SEL_MIX_RGB = 2'd1,
        SEL_MIX_ALL = 2'd2
    } sel_t;

    typedef struct packed {
        sel_t                                 sel;
        logic [ChanCount*ChanWidth-1:0]       pass;
        logic [ChanCount-1:0][SumWidth-1:0]   sum;
    } mul_stage_t;

    typedef struct packed {
        sel_t                                 sel;
        logic [ChanCount*ChanWidth-1:0]       pass;
        logic [ChanCount-1:0][ChanWidth-1:0]  quo;
    } div_stage_t;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [ChanWidth-1:0] div255(input logic [SumWidth-1:0] x);
        logic [SumWidth:0] tmp;
        tmp = {1'b0, x} + {{SumWidth{1'b0}}, 1'b1}
            + {{(ChanWidth+1){1'b0}}, x[SumWidth-1:ChanWidth]};
        return tmp[SumWidth-1:ChanWidth];
    endfunction

endpackage

FILE: sv/pco_mul_stage.sv
// First pipeline stage: operation decode, channel weighting products, saturating steps.
module pco_mul_stage import pco_pkg::*; (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [1:0]                     kind,
    input  logic [ChanCount*ChanWidth-1:0] color_a,
    input  logic [ChanCount*ChanWidth-1:0] color_b,
    input  logic [ChanWidth-1:0]           amount,
    output mul_stage_t                     stage_q
);

    mul_stage_t                     stage_reg;
    mul_stage_t                     stage_next;
    logic [ChanWidth-1:0]           weight;
    logic [ChanWidth-1:0]           weight_inv;
    logic [ChanCount*ChanWidth-1:0] shifted;
    logic [ChanWidth:0]             up_sum;
    logic [ChanWidth-1:0]           chan_v;

    always_comb begin
        weight     = (kind == KIND_BLEND) ? color_b[4*ChanWidth-1 -: ChanWidth] : amount;
        weight_inv = {ChanWidth{1'b1}} - weight;

        // Alpha passes unchanged for lighten and darken.
        shifted = color_a;
        for (int i = 0; i < ChanCount - 1; i++) begin
            chan_v = color_a[i*ChanWidth +: ChanWidth];
            up_sum = {1'b0, chan_v} + {1'b0, amount};
            if (kind == KIND_LIGHTEN) begin
                shifted[i*ChanWidth +: ChanWidth] =
                    up_sum[ChanWidth] ? {ChanWidth{1'b1}} : up_sum[ChanWidth-1:0];
            end else begin
                shifted[i*ChanWidth +: ChanWidth] =
                    (chan_v < amount) ? {ChanWidth{1'b0}} : chan_v - amount;
            end
        end

        for (int i = 0; i < ChanCount; i++) begin
            stage_next.sum[i] =
                SumWidth'(color_a[i*ChanWidth +: ChanWidth] * weight_inv)
              + SumWidth'(color_b[i*ChanWidth +: ChanWidth] * weight);
        end

        stage_next.sel  = SEL_PASS;
        stage_next.pass = color_a;
        unique case (kind)
            KIND_BLEND: begin
                if (weight == '0) begin
                    stage_next.pass = color_a;
                end else if (weight == '1) begin
                    stage_next.pass = color_b;
                end else begin
                    stage_next.sel = SEL_MIX_RGB;
                end
            end
            KIND_LERP: begin
                if (weight == '0) begin
                    stage_next.pass = color_a;
                end else if (weight == '1) begin
                    stage_next.pass = color_b;
                end else begin
                    stage_next.sel = SEL_MIX_ALL;
                end
            end
            KIND_LIGHTEN, KIND_DARKEN: begin
                stage_next.pass = shifted;
            end
            default: begin
                stage_next.pass = color_a;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_q = stage_reg;

endmodule

FILE: sv/pco_div_stage.sv
// Second pipeline stage: divide each weighted channel sum by 255.
module pco_div_stage import pco_pkg::*; (
    input  logic       aclk,
    input  logic       load,
    input  mul_stage_t stage_d,
    output div_stage_t stage_q
);

    div_stage_t stage_reg;
    div_stage_t stage_next;

    always_comb begin
        stage_next.sel  = stage_d.sel;
        stage_next.pass = stage_d.pass;
        for (int i = 0; i < ChanCount; i++) begin
            stage_next.quo[i] = div255(stage_d.sum[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_q = stage_reg;

endmodule

FILE: sv/argb_pixel_color_ops.sv
// Throughput: one transaction per cycle while m_ready stays high; three register stages
//   (products, divide by 255, output select) advance under per-stage valid bits, and a
//   stalled stage holds while bubbles ahead of it still fill.
// Reset: synchronous active-low aresetn clears all stage valid bits; data registers
//   are not reset. No other state.
module argb_pixel_color_ops import pco_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_color_a,
    input  logic [31:0] s_color_b,
    input  logic [7:0]  s_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_color_out
);

    logic        v1_reg, v1_next;
    logic        v2_reg, v2_next;
    logic        v3_reg, v3_next;
    logic        en1, en2, en3;
    mul_stage_t  mul_q;
    div_stage_t  div_q;
    logic [31:0] color_out_reg, color_out_next;

    // A stage loads when it is empty or its contents move on this cycle.
    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_comb begin
        v1_next = en1 ? s_valid : v1_reg;
        v2_next = en2 ? v1_reg  : v2_reg;
        v3_next = en3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: weights, products, lighten/darken and pass-through choice.
    pco_mul_stage u_mul (
        .aclk    (aclk),
        .load    (en1),
        .kind    (s_kind),
        .color_a (s_color_a),
        .color_b (s_color_b),
        .amount  (s_amount),
        .stage_q (mul_q)
    );

    // Stage 2: divide by 255 per channel.
    pco_div_stage u_div (
        .aclk    (aclk),
        .load    (en2),
        .stage_d (mul_q),
        .stage_q (div_q)
    );

    // Stage 3: assemble the output word. Blend forces opaque alpha on a partial mix.
    always_comb begin
        case (div_q.sel)
            SEL_MIX_RGB: color_out_next = {8'hFF, div_q.quo[2], div_q.quo[1], div_q.quo[0]};
            SEL_MIX_ALL: color_out_next = {div_q.quo[3], div_q.quo[2],
                                           div_q.quo[1], div_q.quo[0]};
            default:     color_out_next = div_q.pass;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            color_out_reg <= color_out_next;
        end
    end

    assign m_valid     = v3_reg;
    assign m_color_out = color_out_reg;

endmodule

FILE: bench/argb_pixel_color_ops_tb.sv
// Self-checking testbench for the ARGB pixel color unit: blend, lerp, lighten and darken.
module argb_pixel_color_ops_tb import pco_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // One request as it travels on the input channel.
    typedef struct {
        kind_t       kind;
        logic [31:0] color_a;
        logic [31:0] color_b;
        logic [7:0]  amount;
    } pixel_req_t;

    // One predicted result, tagged with its operation for readable reports.
    typedef struct {
        kind_t       kind;
        logic [31:0] color;
    } pixel_want_t;

    localparam int RandomReqs = 1850;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind      = KIND_BLEND;
    logic [31:0] s_color_a   = '0;
    logic [31:0] s_color_b   = '0;
    logic [7:0]  s_amount    = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_color_out;

    pixel_req_t  pending_reqs[$];
    pixel_want_t expected_pixels[$];

    // Handshake flags captured at the rising edge, consumed at the falling edge.
    logic        req_taken = 1'b0;
    logic        res_taken = 1'b0;

    // Idle bookkeeping for both sides: remaining gap and remaining no-idle stretch.
    int unsigned req_gap   = 0;
    int unsigned req_calm  = 0;
    int unsigned res_stall = 0;
    int unsigned res_calm  = 0;

    int unsigned kind_count[4] = '{default: 0};
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;

    argb_pixel_color_ops uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_color_a   (s_color_a),
        .s_color_b   (s_color_b),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_color_out (m_color_out)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Color arithmetic used for prediction
    // ------------------------------------------------------------------

    // Weighted mix of two 8-bit channels: floor((x*(255-w) + y*w) / 255).
    function automatic logic [7:0] weigh_channel(logic [7:0] x, logic [7:0] y, logic [7:0] w);
        int unsigned acc;
        acc = int'(x) * (255 - int'(w)) + int'(y) * int'(w);
        return 8'(acc / 255);
    endfunction

    // Work out the color the unit should return for one request.
    function automatic logic [31:0] predicted_color(kind_t kind, logic [31:0] ca,
                                                    logic [31:0] cb, logic [7:0] amt);
        logic [31:0] res;
        logic [7:0]  alpha;
        int          v;
        res   = '0;
        alpha = cb[31:24];
        case (kind)
            KIND_BLEND: begin
                // Transparent foreground keeps the background, opaque one replaces it;
                // anything in between weighs R, G, B and forces opaque output alpha.
                if (alpha == 8'd0) begin
                    res = ca;
                end else if (alpha == 8'hFF) begin
                    res = cb;
                end else begin
                    res[31:24] = 8'hFF;
                    for (int p = 0; p < 24; p += 8) begin
                        res[p +: 8] = weigh_channel(ca[p +: 8], cb[p +: 8], alpha);
                    end
                end
            end
            KIND_LERP: begin
                // Endpoints pass a color through untouched; other factors mix all four.
                if (amt == 8'd0) begin
                    res = ca;
                end else if (amt == 8'hFF) begin
                    res = cb;
                end else begin
                    for (int p = 0; p < 32; p += 8) begin
                        res[p +: 8] = weigh_channel(ca[p +: 8], cb[p +: 8], amt);
                    end
                end
            end
            default: begin
                // Lighten saturates at 255, darken clamps at 0; alpha is kept.
                res[31:24] = ca[31:24];
                for (int p = 0; p < 24; p += 8) begin
                    if (kind == KIND_LIGHTEN) begin
                        v = int'(ca[p +: 8]) + int'(amt);
                        res[p +: 8] = (v > 255) ? 8'hFF : 8'(v);
                    end else begin
                        v = int'(ca[p +: 8]) - int'(amt);
                        res[p +: 8] = (v < 0) ? 8'h00 : 8'(v);
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random color, with channels pushed to 00 or FF now and then to hit the clamps.
    function automatic logic [31:0] random_color();
        logic [31:0] c;
        int unsigned pick;
        c = $urandom;
        for (int p = 0; p < 32; p += 8) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                c[p +: 8] = 8'h00;
            end else if (pick == 1) begin
                c[p +: 8] = 8'hFF;
            end
        end
        return c;
    endfunction

    // Random step or factor, biased toward the two ends.
    function automatic logic [7:0] random_amount();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic queue_req(kind_t kind, logic [31:0] ca, logic [31:0] cb, logic [7:0] amt);
        pixel_req_t req;
        req.kind    = kind;
        req.color_a = ca;
        req.color_b = cb;
        req.amount  = amt;
        pending_reqs.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Request driver: present the next queued transaction at the falling edge,
    // hold it until accepted, then idle for a drawn number of cycles.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_requests
        pixel_req_t  req;
        int unsigned gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // Hold: the current transaction has not been taken yet.
        end else if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            req = pending_reqs.pop_front();
            s_kind    <= req.kind;
            s_color_a <= req.color_a;
            s_color_b <= req.color_b;
            s_amount  <= req.amount;
            s_valid   <= 1'b1;
            // Draw the gap that follows this transaction; now and then run a
            // stretch of back-to-back transactions.
            if (req_calm != 0) begin
                req_calm <= req_calm - 1;
                gap = 0;
            end else begin
                if ($urandom_range(0, 24) == 0) begin
                    req_calm <= $urandom_range(16, 48);
                end
                gap = $urandom_range(0, 13);
            end
            req_gap <= gap;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: after each taken result, drop ready for a drawn number of
    // cycles, with occasional stretches of no stalling at all.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        int unsigned stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall = res_stall;
            if (res_taken) begin
                if (res_calm != 0) begin
                    res_calm <= res_calm - 1;
                    stall = 0;
                end else begin
                    if ($urandom_range(0, 24) == 0) begin
                        res_calm <= $urandom_range(16, 48);
                    end
                    stall = $urandom_range(0, 13);
                end
            end
            if (stall != 0) begin
                m_ready   <= 1'b0;
                res_stall <= stall - 1;
            end else begin
                m_ready   <= 1'b1;
                res_stall <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, record accepted requests with their
    // predicted color and check every taken result against the oldest one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : track_transactions
        pixel_want_t want;
        req_taken <= aresetn && s_valid && (s_ready === 1'b1);
        res_taken <= aresetn && (m_valid === 1'b1) && m_ready;
        if (aresetn && s_valid && (s_ready === 1'b1)) begin
            want.kind  = kind_t'(s_kind);
            want.color = predicted_color(kind_t'(s_kind), s_color_a, s_color_b, s_amount);
            expected_pixels.push_back(want);
            kind_count[s_kind]++;
        end
        if (aresetn && (m_valid === 1'b1) && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %08h",
                         $time, m_color_out);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (m_color_out !== want.color) begin
                    $display("%0t: color_out mismatch (%s): expected %08h, got %08h",
                             $time, want.kind.name(), want.color, m_color_out);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, wait for the drain, report.
    // ------------------------------------------------------------------
    initial begin : run_sequence
        kind_t       kind;
        logic [31:0] ca;
        logic [31:0] cb;
        logic [7:0]  amt;
        int unsigned pick;

        // Blend: transparent, opaque, and partial alpha near both ends and midway.
        queue_req(KIND_BLEND, 32'h12345678, 32'h00ABCDEF, 8'hFF);
        queue_req(KIND_BLEND, 32'hFFFFFFFF, 32'hFF000000, 8'h00);
        queue_req(KIND_BLEND, 32'h00000000, 32'h01FFFFFF, 8'h00);
        queue_req(KIND_BLEND, 32'hFFFFFFFF, 32'hFE000000, 8'hA5);
        queue_req(KIND_BLEND, 32'h80204060, 32'h80E0C0A0, 8'h5A);
        queue_req(KIND_BLEND, 32'h00FFFFFF, 32'h7F000000, 8'h01);
        // Lerp: both endpoints, the factors next to them, and the middle.
        queue_req(KIND_LERP, 32'h00000000, 32'hFFFFFFFF, 8'h00);
        queue_req(KIND_LERP, 32'h00000000, 32'hFFFFFFFF, 8'hFF);
        queue_req(KIND_LERP, 32'h00000000, 32'hFFFFFFFF, 8'h01);
        queue_req(KIND_LERP, 32'hFFFFFFFF, 32'h00000000, 8'hFE);
        queue_req(KIND_LERP, 32'hFFFFFFFF, 32'h00000000, 8'h80);
        queue_req(KIND_LERP, 32'hFF00FF00, 32'h00FF00FF, 8'h55);
        // Lighten: saturation, zero step, full step; color_b carries noise.
        queue_req(KIND_LIGHTEN, 32'h80F0F0F0, 32'hFFFFFFFF, 8'h20);
        queue_req(KIND_LIGHTEN, 32'h12345678, 32'hDEADBEEF, 8'h00);
        queue_req(KIND_LIGHTEN, 32'h00000000, 32'hFFFFFFFF, 8'hFF);
        queue_req(KIND_LIGHTEN, 32'h7F00FF10, 32'h00000000, 8'h10);
        // Darken: clamping, zero step, full step.
        queue_req(KIND_DARKEN, 32'h80101010, 32'hFFFFFFFF, 8'h20);
        queue_req(KIND_DARKEN, 32'h12345678, 32'hDEADBEEF, 8'h00);
        queue_req(KIND_DARKEN, 32'hFFFFFFFF, 32'h00000000, 8'hFF);
        queue_req(KIND_DARKEN, 32'h7F00FF10, 32'hFFFFFFFF, 8'h10);

        // Random part: push the blend alpha and the lerp factor to their
        // pass-through values often enough to hit them many times.
        for (int i = 0; i < RandomReqs; i++) begin
            kind = kind_t'($urandom_range(0, 3));
            ca   = random_color();
            cb   = random_color();
            amt  = random_amount();
            pick = $urandom_range(0, 5);
            if (kind == KIND_BLEND) begin
                if (pick == 0) begin
                    cb[31:24] = 8'h00;
                end else if (pick == 1) begin
                    cb[31:24] = 8'hFF;
                end
            end else if (kind == KIND_LERP) begin
                if (pick == 0) begin
                    amt = 8'h00;
                end else if (pick == 1) begin
                    amt = 8'hFF;
                end
            end
            queue_req(kind, ca, cb, amt);
        end

        // Hold reset, then release it on a falling edge.
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait until every request is taken and every result is back.
        while (pending_reqs.size() != 0 || s_valid || expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        // Give the pipeline a few more cycles to show any stray result.
        repeat (8) @(posedge aclk);

        $display("summary: %0d requests (blend %0d, lerp %0d, lighten %0d, darken %0d)",
                 kind_count[KIND_BLEND] + kind_count[KIND_LERP]
                     + kind_count[KIND_LIGHTEN] + kind_count[KIND_DARKEN],
                 kind_count[KIND_BLEND], kind_count[KIND_LERP],
                 kind_count[KIND_LIGHTEN], kind_count[KIND_DARKEN]);
        $display("summary: %0d results checked under random stalls, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("argb_pixel_color_ops_tb: done, clean");
        end else begin
            $display("argb_pixel_color_ops_tb: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("timeout: %0d results still expected", expected_pixels.size());
        $display("argb_pixel_color_ops_tb: done, errors");
        $finish;
    end

endmodule
